// ===== rtl/owsrs_pkg.sv =====
// Package for the one-way scan request sorter.
// Holds the queue depth, the derived widths, the request/result structs and
// the types shared by the cell row and the top level. No dependencies.
package owsrs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic
    {
        FUNC_INSERT = 1'b0,
        FUNC_TAKE   = 1'b1
    } func_t;

    typedef struct packed
    {
        func_t       func;
        logic [15:0] cylinder;
        logic [31:0] block;
        logic [7:0]  request_tag;
    } req_t;

    typedef struct packed
    {
        logic        accepted;
        logic [4:0]  slot;
        logic [15:0] head_cylinder;
        logic [31:0] head_block;
        logic [7:0]  head_tag;
        logic [4:0]  occupancy;
    } rsp_t;

    typedef struct packed
    {
        logic [15:0] cylinder;
        logic [31:0] block;
        logic [7:0]  tag;
    } entry_t;

    // per-cell load selection, driven by the top level
    typedef struct packed
    {
        logic load_new;
        logic from_prev;
        logic from_next;
    } cell_ctl_t;

    // per-cell compare results, seen by the top level
    typedef struct packed
    {
        logic ahead;    // new request orders ahead of this entry
        logic inv;      // this entry's cylinder is below its predecessor's
    } cell_flags_t;

    typedef enum logic
    {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

// ===== rtl/one_way_scan_request_sorter_core.sv =====
// One-way scan request sorter, top level.
// Instantiates the row of owsrs_cell positions; depends on owsrs_pkg.
//
// Usage:
//   req channel (req_valid/req_ready/req): func = insert or take, with the
//   cylinder, block and tag of an insert. rsp channel (rsp_valid/rsp_ready/
//   rsp): one result per request.
//   Position 0 is the active head and is never displaced by an insert. An
//   insert at or past the head's cylinder joins the first ascending run;
//   a lower one joins the second run after the inversion (or starts it at
//   the tail). A take returns the head and shifts the row down by one.
//   Timing: a request is registered on acceptance and executed in the
//   EXEC state that follows once the result slot is free; every cell
//   compares, picks its source and loads at once; the result is registered
//   at that edge. The FSM takes no new request until the last one executes.
//   Stall: the result register holds until rsp_ready; the next request may
//   be accepted meanwhile, but it does not execute until the result slot
//   frees up.
//   Reset: the queue is empty and both channels idle; entry contents are
//   not cleared (only positions below the count are ever read).
module one_way_scan_request_sorter_core
    import owsrs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    state_t             state_reg;
    state_t             state_next;
    req_t               req_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;

    entry_t             new_entry;
    entry_t             entries [QUEUE_DEPTH];
    cell_flags_t        flags   [QUEUE_DEPTH];
    cell_ctl_t          ctl     [QUEUE_DEPTH];

    logic [QUEUE_DEPTH-1:0] occupied;
    logic [QUEUE_DEPTH-1:0] inv_v;
    logic [QUEUE_DEPTH-1:0] seen_inv;
    logic [QUEUE_DEPTH-1:0] cond;
    logic [QUEUE_DEPTH-1:0] mark;
    logic [QUEUE_DEPTH-1:0] ins;
    logic [IDX_W-1:0]       slot_idx;

    logic first_run;
    logic accept;
    logic exec_go;
    logic do_ins;
    logic do_take;

    assign new_entry = '{cylinder: req_reg.cylinder, block: req_reg.block,
                         tag: req_reg.request_tag};

    // ---------------- cell row ----------------
    for (genvar k = 0; k < QUEUE_DEPTH; k++)
    begin : g_cell
        owsrs_cell u_cell
        (
            .clk        (clk),
            .new_entry  (new_entry),
            .prev_entry (entries[(k == 0) ? 0 : k - 1]),
            .next_entry (entries[(k == QUEUE_DEPTH - 1) ? k : k + 1]),
            .ctl        (ctl[k]),
            .entry      (entries[k]),
            .flags      (flags[k])
        );

        assign seen_inv[k] = |inv_v[k:0];
        assign mark[k]     = |cond[k:0];
    end

    // ---------------- insert position ----------------
    assign first_run = req_reg.cylinder >= entries[0].cylinder;

    always_comb
    begin
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            occupied[k] = CNT_W'(k) < count_reg;
            inv_v[k]    = (k != 0) && occupied[k] && flags[k].inv;
        end
    end

    always_comb
    begin
        cond[0] = count_reg == '0;
        for (int k = 1; k < QUEUE_DEPTH; k++)
        begin
            // the tail position catches a request that orders after everything
            cond[k] = (count_reg == CNT_W'(k)) ||
                      (occupied[k] && (first_run ? (inv_v[k] || flags[k].ahead)
                                                 : (seen_inv[k] && flags[k].ahead)));
        end
    end

    always_comb
    begin
        ins[0]   = mark[0];
        slot_idx = '0;
        for (int k = 1; k < QUEUE_DEPTH; k++)
            ins[k] = mark[k] && !mark[k-1];
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            if (ins[k])
                slot_idx = slot_idx | IDX_W'(k);
        end
    end

    // ---------------- control ----------------
    assign accept  = req_valid && req_ready;
    assign exec_go = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp_ready);
    assign do_ins  = exec_go && (req_reg.func == FUNC_INSERT) &&
                     (count_reg != CNT_W'(QUEUE_DEPTH));
    assign do_take = exec_go && (req_reg.func == FUNC_TAKE) && (count_reg != '0);

    always_comb
    begin
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            ctl[k].load_new  = do_ins && ins[k];
            ctl[k].from_prev = do_ins && (k != 0) && mark[(k == 0) ? 0 : k - 1];
            ctl[k].from_next = do_take && (k != QUEUE_DEPTH - 1);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        req_ready      = (state_reg == ST_IDLE);

        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    if (do_ins)
                        count_next = count_reg + CNT_W'(1);
                    else if (do_take)
                        count_next = count_reg - CNT_W'(1);

                    rsp_next.accepted      = do_ins || do_take;
                    rsp_next.slot          = do_ins ? 5'(slot_idx) : 5'd0;
                    rsp_next.head_cylinder = do_take ? entries[0].cylinder : 16'd0;
                    rsp_next.head_block    = do_take ? entries[0].block : 32'd0;
                    rsp_next.head_tag      = do_take ? entries[0].tag : 8'd0;
                    rsp_next.occupancy     = 5'(count_next);
                    rsp_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= req;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/owsrs_cell.sv =====
// One queue position of the request sorter: holds one entry, compares it
// against the pending request and its predecessor, and loads from the
// request or either neighbor. Depends on owsrs_pkg.
module owsrs_cell
    import owsrs_pkg::*;
(
    input  logic        clk,
    input  entry_t      new_entry,
    input  entry_t      prev_entry,
    input  entry_t      next_entry,
    input  cell_ctl_t   ctl,
    output entry_t      entry,
    output cell_flags_t flags
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        flags.ahead  = (new_entry.cylinder < entry_reg.cylinder) ||
                       ((new_entry.cylinder == entry_reg.cylinder) &&
                        (new_entry.block < entry_reg.block));
        flags.inv    = entry_reg.cylinder < prev_entry.cylinder;
    end

    always_comb
    begin
        if (ctl.load_new)
            entry_next = new_entry;
        else if (ctl.from_prev)
            entry_next = prev_entry;
        else if (ctl.from_next)
            entry_next = next_entry;
        else
            entry_next = entry_reg;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/owsrs_checker.sv =====
// Port-level checks for the one-way scan request sorter, bound to the top
// level below. Depends on owsrs_pkg and one_way_scan_request_sorter_core.
module owsrs_checker
    import owsrs_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    // one request at a time: right after an accept the port is closed
    a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted back to back");

    // a result only appears right after the block was busy executing
    a_rsp_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("result without a preceding request");

    // refused inserts and empty takes carry all-zero side fields
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.accepted |-> (rsp.slot == 5'd0) &&
            (rsp.head_cylinder == 16'd0) && (rsp.head_block == 32'd0) &&
            (rsp.head_tag == 8'd0))
        else $error("refused result has nonzero fields");

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

endmodule

bind one_way_scan_request_sorter_core owsrs_checker u_owsrs_checker (.*);

// ===== sim/tb_one_way_scan_request_sorter_core.sv =====
// Testbench for one_way_scan_request_sorter_core: directed and random requests
// checked against an in-bench model of the C-SCAN ordered queue.
// Depends on owsrs_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_one_way_scan_request_sorter_core;
    import owsrs_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    // model of the queue contents, position 0 is the active head
    entry_t      sweep_q [QUEUE_DEPTH];
    int unsigned sweep_len = 0;

    rsp_t        pending_rsp [$];
    int unsigned errors = 0;
    int unsigned burst_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned cycle_cnt = 0;
    int unsigned ready_mode = 0;

    one_way_scan_request_sorter_core u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // position (1..n) a new request takes in a non-empty queue
    function automatic int unsigned landing_slot(logic [15:0] cyl, logic [31:0] blk);
        int unsigned i;
        bit          low_run;
        entry_t      nxt;
        i = 0;
        low_run = (cyl < sweep_q[0].cylinder);
        // below the head: skip to the inversion (or the tail)
        if (low_run)
            while (i + 1 < sweep_len && sweep_q[i + 1].cylinder >= sweep_q[i].cylinder)
                i++;
        while (i + 1 < sweep_len)
        begin
            nxt = sweep_q[i + 1];
            if (cyl < nxt.cylinder || (cyl == nxt.cylinder && blk < nxt.block))
                return i + 1;
            if (!low_run && nxt.cylinder < sweep_q[i].cylinder)
                return i + 1;
            i++;
        end
        return i + 1;
    endfunction

    function automatic rsp_t schedule_request(req_t r);
        rsp_t        res;
        int unsigned pos;
        int          k;
        res = '0;
        if (r.func == FUNC_INSERT)
        begin
            if (sweep_len < QUEUE_DEPTH)
            begin
                pos = (sweep_len == 0) ? 0 : landing_slot(r.cylinder, r.block);
                for (k = sweep_len; k > pos; k--)
                    sweep_q[k] = sweep_q[k - 1];
                sweep_q[pos] = '{cylinder: r.cylinder, block: r.block, tag: r.request_tag};
                sweep_len++;
                res.accepted = 1'b1;
                res.slot     = pos[4:0];
            end
        end
        else if (sweep_len > 0)
        begin
            res.head_cylinder = sweep_q[0].cylinder;
            res.head_block    = sweep_q[0].block;
            res.head_tag      = sweep_q[0].tag;
            for (k = 0; k + 1 < sweep_len; k++)
                sweep_q[k] = sweep_q[k + 1];
            sweep_len--;
            res.accepted = 1'b1;
        end
        res.occupancy = sweep_len[4:0];
        return res;
    endfunction

    function automatic req_t random_request(int unsigned insert_pct);
        req_t        r;
        int unsigned pick;
        r.func = ($urandom_range(99, 0) < insert_pct) ? FUNC_INSERT : FUNC_TAKE;
        pick = $urandom_range(9, 0);
        // cluster cylinders so ties and both runs show up often
        if (pick < 5)
            r.cylinder = 16'($urandom_range(65535, 0));
        else if (pick < 9)
            r.cylinder = 16'd1000 + 16'($urandom_range(15, 0));
        else
            r.cylinder = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
        r.block       = $urandom_range(1, 0) ? $urandom : $urandom_range(3, 0);
        r.request_tag = 8'($urandom_range(255, 0));
        return r;
    endfunction

    function automatic req_t make_insert(logic [15:0] cyl, logic [31:0] blk, logic [7:0] tag);
        req_t r;
        r.func        = FUNC_INSERT;
        r.cylinder    = cyl;
        r.block       = blk;
        r.request_tag = tag;
        return r;
    endfunction

    function automatic req_t make_take();
        req_t r;
        r             = random_request(0);
        r.func        = FUNC_TAKE;
        return r;
    endfunction

    // called at a rising edge; returns at the edge that accepts the request
    task automatic send_request(req_t r);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(6, 0);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(7, 0) == 0) ? 48 : $urandom_range(10, 1);
        end
        burst_left--;
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        pending_rsp.push_back(schedule_request(r));
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        burst_left = 0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            errors++;
        end
    endtask

    task automatic check_result(rsp_t got);
        rsp_t exp_r;
        if (pending_rsp.size() == 0)
        begin
            $error("result with no request outstanding");
            errors++;
        end
        else
        begin
            exp_r = pending_rsp.pop_front();
            report_field("accepted", exp_r.accepted, got.accepted);
            report_field("slot", exp_r.slot, got.slot);
            report_field("head_cylinder", exp_r.head_cylinder, got.head_cylinder);
            report_field("head_block", exp_r.head_block, got.head_block);
            report_field("head_tag", exp_r.head_tag, got.head_tag);
            report_field("occupancy", exp_r.occupancy, got.occupancy);
        end
    endtask

    // result side: check, then pick the next ready value
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt % 97 == 0)
            ready_mode = $urandom_range(3, 0);
        if (rst_n && rsp_valid && rsp_ready)
            check_result(rsp);
        case (ready_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(1, 0));
            2: rsp_ready <= ($urandom_range(5, 0) == 0);
            default: rsp_ready <= cycle_cnt[1];
        endcase
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_empty_queue();
        send_request(make_take());
        send_request(make_insert(16'd1000, 32'd5, 8'h01));
        send_request(make_take());
        send_request(make_take());
    endtask

    // both runs, the inversion, ties and field extremes
    task automatic test_sweep_order();
        send_request(make_insert(16'd500, 32'd100, 8'h10));
        send_request(make_insert(16'd500, 32'd50, 8'h11));
        send_request(make_insert(16'd800, 32'd0, 8'h12));
        send_request(make_insert(16'd200, 32'd7, 8'h13));
        send_request(make_insert(16'd100, 32'd9, 8'h14));
        send_request(make_insert(16'd200, 32'd0, 8'h15));
        send_request(make_insert(16'hFFFF, 32'hFFFF_FFFF, 8'hFF));
        send_request(make_insert(16'h0000, 32'h0000_0000, 8'h00));
        send_request(make_insert(16'd500, 32'd100, 8'h16));
        send_request(make_insert(16'd650, 32'hAAAA_5555, 8'h55));
        while (sweep_len > 0)
            send_request(make_take());
    endtask

    // fill past full so inserts get refused, then drain past empty
    task automatic test_full_queue();
        while (sweep_len < QUEUE_DEPTH)
            send_request(random_request(100));
        repeat (2) send_request(random_request(100));
        while (sweep_len > 0)
            send_request(make_take());
        send_request(make_take());
    endtask

    task automatic test_random_mix(int unsigned count, int unsigned insert_pct);
        repeat (count) send_request(random_request(insert_pct));
    endtask

    initial
    begin
        clk       = 1'b0;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_sweep_order();
        wait_idle();
        test_random_mix(150, 75);
        test_full_queue();
        test_random_mix(100, 30);
        wait_idle();
        test_random_mix(150, 55);
        test_full_queue();
        test_random_mix(80, 65);

        wait_idle();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/owsrs_pkg.sv
rtl/owsrs_cell.sv
rtl/one_way_scan_request_sorter_core.sv
rtl/owsrs_checker.sv
sim/tb_one_way_scan_request_sorter_core.sv
